>>> sv/chb_pkg.sv
package chb_pkg;

  // Fixed widths of the sample and result fields
  localparam int SAMPLE_BITS = 8;
  localparam int CODE_W      = 15;
  localparam int OUT_COUNT_W = 16;
  localparam int DISTINCT_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE = 2'd0,
    CFG_GRAY_BITS  = 2'd1,
    CFG_COLOR_BITS = 2'd2
  } cfg_idx_t;

  // One classified command
  typedef struct packed {
    func_t             op;
    logic [CODE_W-1:0] code;
  } cmd_t;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Status from the back end
  typedef struct packed {
    logic clearing;
    logic result_wait;
  } back_status_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_RESULT
  } back_state_t;

  // Keep the top k bits of a sample; k of zero keeps nothing
  function automatic logic [SAMPLE_BITS-1:0] top_bits(input logic [SAMPLE_BITS-1:0] sample,
                                                       input logic [2:0] k);
    logic [3:0] sh;
    sh = 4'(SAMPLE_BITS) - {1'b0, k};
    return (k == 3'd0) ? '0 : (sample >> sh);
  endfunction

endpackage

>>> sv/chb_front.sv
module chb_front import chb_pkg::*; #(
  parameter int CODE_BITS = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            func,
  input  logic [SAMPLE_BITS-1:0] red_or_gray,
  input  logic [SAMPLE_BITS-1:0] green,
  input  logic [SAMPLE_BITS-1:0] blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  input  back_status_t          bk_status,
  output logic                  push,
  output cmd_t                  push_cmd
);

  localparam int MAX_CK = CODE_BITS / 3;

  logic       color_mode;
  logic [2:0] gray_bits;
  logic [2:0] color_bits;

  logic [2:0]           kc;
  logic [23:0]          wide;
  logic [CODE_BITS-1:0] code;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= 1'b1;
      gray_bits  <= 3'd4;
      color_bits <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLOR_MODE: color_mode <= cfg_data[0];
        CFG_GRAY_BITS:  gray_bits  <= cfg_data;
        CFG_COLOR_BITS: color_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // Quantize the pixel; color bits per channel capped so R,G,B fit the code
  assign kc   = (color_bits > 3'(MAX_CK)) ? 3'(MAX_CK) : color_bits;
  assign wide = (24'(top_bits(red_or_gray, kc)) << {kc, 1'b0}) |
                (24'(top_bits(green, kc)) << kc) |
                24'(top_bits(blue, kc));
  assign code = color_mode ? wide[CODE_BITS-1:0]
                           : CODE_BITS'(top_bits(red_or_gray, gray_bits));

  assign push_cmd.op   = func_t'(func);
  assign push_cmd.code = CODE_W'(code);

  // Hold off input while the queue is full or the store is being cleared
  assign in_stall = q_full || bk_status.clearing;

  // Unused function code is accepted and dropped
  always_comb begin
    push = 1'b0;
    if (in_valid && !in_stall) begin
      unique case (func) inside
        FUNC_ADD, FUNC_READ, FUNC_CLEAR: push = 1'b1;
        default:                         push = 1'b0;
      endcase
    end
  end

endmodule

>>> sv/chb_queue.sv
module chb_queue import chb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  output logic    full,
  output q_head_t head,
  input  logic    pop
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/chb_back.sv
module chb_back import chb_pkg::*; #(
  parameter int CODE_BITS  = 15,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  q_head_t                head,
  output logic                   pop,
  output back_status_t           status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CODE_W-1:0]      bin_code,
  output logic [OUT_COUNT_W-1:0] bin_count,
  output logic [DISTINCT_W-1:0]  distinct_codes,
  output logic                   readout_done
);

  localparam int DEPTH = 1 << CODE_BITS;
  localparam int PTR_W = CODE_BITS + 1;

  back_state_t state, state_next;

  // Bin store
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata;
  logic                  mem_re;
  logic [CODE_BITS-1:0]  mem_raddr;
  logic                  mem_we;
  logic [CODE_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  logic [CODE_BITS-1:0]   clr_addr;
  logic [CODE_BITS-1:0]   add_addr;
  logic [PTR_W-1:0]       ptr;
  logic [PTR_W-1:0]       scan_addr;
  logic                   pend_vld;
  logic [CODE_BITS-1:0]   pend_addr;
  logic [DISTINCT_W-1:0]  distinct;
  logic [CODE_BITS-1:0]   res_code;
  logic [OUT_COUNT_W-1:0] res_count;
  logic                   res_done;

  logic                   found;
  logic                   scan_end;
  logic                   out_free;
  logic [OUT_COUNT_W-1:0] cnt_sat;

  assign found    = pend_vld && (rdata != '0);
  assign scan_end = scan_addr[CODE_BITS];
  assign out_free = !out_valid || !out_stall;

  // Reported count saturates at the result field width
  generate
    if (COUNT_BITS > OUT_COUNT_W) begin : g_sat
      assign cnt_sat = (|rdata[COUNT_BITS-1:OUT_COUNT_W]) ? '1 : rdata[OUT_COUNT_W-1:0];
    end else begin : g_ext
      assign cnt_sat = OUT_COUNT_W'(rdata);
    end
  endgenerate

  assign status.clearing    = (state == ST_CLEAR);
  assign status.result_wait = (state == ST_RESULT);

  // Memory, registered read
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.op)
            FUNC_ADD:   state_next = ST_ADD;
            FUNC_READ:  state_next = ST_SCAN;
            FUNC_CLEAR: state_next = ST_CLEAR;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: state_next = ST_IDLE;
      ST_SCAN: begin
        if (found || scan_end) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Memory controls and queue pop
  always_comb begin
    pop       = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = head.cmd.code[CODE_BITS-1:0];
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        pop    = head.valid;
        mem_re = head.valid && (head.cmd.op == FUNC_ADD);
      end
      ST_ADD: begin
        mem_we    = 1'b1;
        mem_waddr = add_addr;
        mem_wdata = (rdata == '1) ? rdata : rdata + 1'b1;
      end
      ST_SCAN: begin
        mem_re    = !found && !scan_end;
        mem_raddr = scan_addr[CODE_BITS-1:0];
      end
      ST_RESULT: ;
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      ptr      <= '0;
      distinct <= '0;
      pend_vld <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ST_IDLE: begin
          if (head.valid) begin
            add_addr  <= head.cmd.code[CODE_BITS-1:0];
            scan_addr <= ptr;
            pend_vld  <= 1'b0;
            if (head.cmd.op == FUNC_CLEAR) begin
              ptr      <= '0;
              distinct <= '0;
            end
          end
        end
        ST_ADD: begin
          if (rdata == '0) distinct <= distinct + 1'b1;
        end
        ST_SCAN: begin
          pend_vld  <= mem_re;
          pend_addr <= scan_addr[CODE_BITS-1:0];
          if (mem_re) scan_addr <= scan_addr + 1'b1;
          if (found) begin
            res_code  <= pend_addr;
            res_count <= cnt_sat;
            res_done  <= 1'b0;
            ptr       <= PTR_W'(pend_addr) + PTR_W'(1);
          end else if (scan_end) begin
            res_code  <= '0;
            res_count <= '0;
            res_done  <= 1'b1;
            ptr       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      bin_code       <= CODE_W'(res_code);
      bin_count      <= res_count;
      distinct_codes <= distinct;
      readout_done   <= res_done;
    end
  end

endmodule

>>> sv/color_histogram_builder.sv
// Quantized color histogram.
// Input channel (in_valid/in_stall) takes one item: func 0 adds a pixel,
// func 1 reads the next nonzero bin, func 2 clears; func 3 is dropped.
// Output channel (out_valid/out_stall) returns one transaction per read
// item: bin code, count, distinct code total and a done flag that ends a
// pass (the next read starts again from code 0).
// Config channel (cfg_valid/cfg_ready, always ready) writes color_mode,
// gray_bits and color_bits by index; write only while the block is idle.
// A four-entry command queue sits between the input and the bin engine.
// Add: the engine reads the bin, then writes back the incremented count.
// Read: the scan reads one memory address per cycle from the current
// pointer until it finds a nonzero bin or passes the last code.
// After reset and after each clear item the engine zeroes every entry of
// the store, one entry per cycle; in_stall is high during that pass.
// A stalled result stays in the output register; the engine then waits
// with the next result while the queue keeps taking items until full.
module color_histogram_builder import chb_pkg::*; #(
  parameter int CODE_BITS  = 15,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             func,
  input  logic [SAMPLE_BITS-1:0] red_or_gray,
  input  logic [SAMPLE_BITS-1:0] green,
  input  logic [SAMPLE_BITS-1:0] blue,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CODE_W-1:0]      bin_code,
  output logic [OUT_COUNT_W-1:0] bin_count,
  output logic [DISTINCT_W-1:0]  distinct_codes,
  output logic                   readout_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic         q_full;
  logic         q_push;
  cmd_t         q_cmd;
  q_head_t      q_head;
  logic         q_pop;
  back_status_t bk_status;

  chb_front #(.CODE_BITS(CODE_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .red_or_gray (red_or_gray),
    .green       (green),
    .blue        (blue),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .bk_status   (bk_status),
    .push        (q_push),
    .push_cmd    (q_cmd)
  );

  chb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .head     (q_head),
    .pop      (q_pop)
  );

  chb_back #(.CODE_BITS(CODE_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .pop            (q_pop),
    .status         (bk_status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bin_code       (bin_code),
    .bin_count      (bin_count),
    .distinct_codes (distinct_codes),
    .readout_done   (readout_done)
  );

`ifndef NO_ASSERTIONS
  // Reset always starts a clearing pass that holds off input
  a_reset_clears: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // No command leaves the queue during a clearing pass
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    bk_status.clearing |-> !q_pop)
    else $error("queue popped while clearing");

  // The queue is popped only when it holds a command
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head.valid)
    else $error("pop from empty queue");

  // A new result comes only from a finished readout
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(bk_status.result_wait))
    else $error("result without readout");
`endif

endmodule

>>> bench/histogram_checker.sv
// Watches the item, result and register channels of the histogram block,
// keeps its own copy of the bin store and predicts each readout transaction.
module histogram_checker import chb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             func,
  input  logic [SAMPLE_BITS-1:0] red_or_gray,
  input  logic [SAMPLE_BITS-1:0] green,
  input  logic [SAMPLE_BITS-1:0] blue,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [CODE_W-1:0]      bin_code,
  input  logic [OUT_COUNT_W-1:0] bin_count,
  input  logic [DISTINCT_W-1:0]  distinct_codes,
  input  logic                   readout_done,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     reports_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BIN_DEPTH = 1 << CODE_W;
  localparam int MAX_KEEP  = CODE_W / 3;

  typedef struct packed {
    logic [CODE_W-1:0]      code;
    logic [OUT_COUNT_W-1:0] count;
    logic [DISTINCT_W-1:0]  distinct;
    logic                   done;
  } bin_report_t;

  bin_report_t            pending_reports[$];
  logic [OUT_COUNT_W-1:0] tally [BIN_DEPTH];
  int unsigned            scan_ptr;
  logic [DISTINCT_W-1:0]  distinct_seen;
  logic                   color_on;
  logic [2:0]             keep_gray;
  logic [2:0]             keep_color;
  int                     errors = 0;

  // top k bits of a sample, right aligned; k of zero gives zero
  function automatic logic [CODE_W-1:0] upper_bits(input logic [SAMPLE_BITS-1:0] s,
                                                   input int k);
    if (k == 0) return '0;
    return CODE_W'(s >> (SAMPLE_BITS - k));
  endfunction

  // bin code of one pixel under the current register settings
  function automatic logic [CODE_W-1:0] pixel_to_code(input logic [SAMPLE_BITS-1:0] r,
                                                      input logic [SAMPLE_BITS-1:0] g,
                                                      input logic [SAMPLE_BITS-1:0] b);
    int k;
    if (!color_on) return upper_bits(r, keep_gray);
    // per-channel width is capped so three channels fit the code
    k = (keep_color > MAX_KEEP) ? MAX_KEEP : int'(keep_color);
    return (upper_bits(r, k) << (2 * k)) | (upper_bits(g, k) << k) | upper_bits(b, k);
  endfunction

  function automatic void wipe_histogram();
    foreach (tally[i]) tally[i] = '0;
    scan_ptr      = 0;
    distinct_seen = '0;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%t ERROR %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    bin_report_t       want;
    logic [CODE_W-1:0] code;
    int unsigned       p;
    if (rst) begin
      wipe_histogram();
      color_on   = 1'b1;
      keep_gray  = 3'd4;
      keep_color = 3'd3;
      pending_reports.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $display("%t ERROR result: expected none, got code %0d count %0d distinct %0d done %0b",
                   $time, bin_code, bin_count, distinct_codes, readout_done);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("bin_code", want.code, bin_code);
          check_field("bin_count", want.count, bin_count);
          check_field("distinct_codes", want.distinct, distinct_codes);
          check_field("readout_done", want.done, readout_done);
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COLOR_MODE: color_on   = cfg_data[0];
          CFG_GRAY_BITS:  keep_gray  = cfg_data;
          CFG_COLOR_BITS: keep_color = cfg_data;
          default: ;
        endcase
      end

      // item transaction
      if (in_valid && !in_stall) begin
        case (func)
          FUNC_ADD: begin
            code = pixel_to_code(red_or_gray, green, blue);
            if (tally[code] == '0) distinct_seen++;
            if (tally[code] != '1) tally[code]++;
          end
          FUNC_READ: begin
            p = scan_ptr;
            while (p < BIN_DEPTH && tally[p] == '0) p++;
            if (p < BIN_DEPTH) begin
              want     = '{CODE_W'(p), tally[p], distinct_seen, 1'b0};
              scan_ptr = p + 1;
            end else begin
              // pass exhausted: rewind for the next readout
              want     = '{'0, '0, distinct_seen, 1'b1};
              scan_ptr = 0;
            end
            pending_reports.push_back(want);
          end
          FUNC_CLEAR: wipe_histogram();
          default: ;  // unused code is dropped
        endcase
      end
    end
    fail_count      <= errors;
    reports_waiting <= pending_reports.size();
  end

endmodule

>>> bench/tb_color_histogram_builder.sv
module tb_color_histogram_builder import chb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             func = FUNC_ADD;
  logic [SAMPLE_BITS-1:0] red_or_gray = '0;
  logic [SAMPLE_BITS-1:0] green = '0;
  logic [SAMPLE_BITS-1:0] blue = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CODE_W-1:0]      bin_code;
  logic [OUT_COUNT_W-1:0] bin_count;
  logic [DISTINCT_W-1:0]  distinct_codes;
  logic                   readout_done;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_COLOR_MODE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int   fail_count;
  int   reports_waiting;
  int   tx_idle_pct = 13;
  int   rx_idle_pct = 53;
  int   reads_sent = 0;
  int   results_seen = 0;
  int   dones_seen = 0;
  logic last_done = 1'b0;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;

  color_histogram_builder uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .red_or_gray(red_or_gray), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_code(bin_code), .bin_count(bin_count),
    .distinct_codes(distinct_codes), .readout_done(readout_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  histogram_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .red_or_gray(red_or_gray), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_code(bin_code), .bin_count(bin_count),
    .distinct_codes(distinct_codes), .readout_done(readout_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .reports_waiting(reports_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side backpressure; one long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // track result transactions to pace the stimulus
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      last_done    <= readout_done;
      if (readout_done) dones_seen <= dones_seen + 1;
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= op;
    red_or_gray <= r;
    green       <= g;
    blue        <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == FUNC_READ) reads_sent++;
  endtask

  // drop valid, wait for every readout, then let queued adds drain
  task automatic quiesce();
    in_valid <= 1'b0;
    while (results_seen < reads_sent) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(input logic m, input logic [2:0] g, input logic [2:0] c);
    cfg_idx_t   regs [3];
    logic [2:0] vals [3];
    regs = '{CFG_COLOR_MODE, CFG_GRAY_BITS, CFG_COLOR_BITS};
    vals = '{{2'b00, m}, g, c};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // one read at a time until the pass reports done
  task automatic read_all_bins();
    do begin
      send_item(FUNC_READ, rnd8(), rnd8(), rnd8());
      in_valid <= 1'b0;
      while (results_seen < reads_sent) @(posedge clk);
    end while (!last_done);
  endtask

  initial begin
    int          roll;
    int          clears_left;
    int          phase_dones;
    logic        cm;
    logic [2:0]  gb;
    logic [2:0]  cb;
    logic [23:0] palette [8];
    logic [23:0] pix;
    logic [1:0]  op;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme codes, ignored code, readout with adds behind and ahead
    set_config(1'b1, 3'd4, 3'd5);
    send_item(FUNC_ADD, 8'hFF, 8'hFF, 8'hFF);
    send_item(FUNC_ADD, 8'h00, 8'h00, 8'h00);
    send_item(FUNC_ADD, 8'h80, 8'h7F, 8'h01);
    send_item(FUNC_UNUSED, 8'h5A, 8'hA5, 8'h3C);
    send_item(FUNC_READ, rnd8(), rnd8(), rnd8());
    send_item(FUNC_READ, rnd8(), rnd8(), rnd8());
    send_item(FUNC_ADD, 8'h00, 8'h00, 8'h00);
    send_item(FUNC_ADD, 8'hF8, 8'h80, 8'h00);
    read_all_bins();
    send_item(FUNC_READ, rnd8(), rnd8(), rnd8());
    quiesce();
    // zero bits kept in gray mode, shared store across modes
    set_config(1'b0, 3'd0, 3'd7);
    send_item(FUNC_ADD, 8'hAB, 8'h12, 8'h34);
    quiesce();
    // color width above the cap
    set_config(1'b1, 3'd0, 3'd7);
    send_item(FUNC_ADD, 8'hFF, 8'h00, 8'hFF);
    quiesce();
    set_config(1'b1, 3'd7, 3'd0);
    send_item(FUNC_ADD, 8'h55, 8'hAA, 8'hFF);
    quiesce();
    set_config(1'b1, 3'd7, 3'd6);
    send_item(FUNC_ADD, 8'h12, 8'h34, 8'h56);
    quiesce();
    set_config(1'b0, 3'd7, 3'd6);
    send_item(FUNC_ADD, 8'hFF, 8'h00, 8'h00);
    send_item(FUNC_ADD, 8'h01, 8'hFF, 8'hFF);
    read_all_bins();
    // clear, then an empty readout
    send_item(FUNC_CLEAR, rnd8(), rnd8(), rnd8());
    send_item(FUNC_READ, rnd8(), rnd8(), rnd8());
    send_item(FUNC_ADD, 8'h7F, 8'h00, 8'h00);
    send_item(FUNC_READ, rnd8(), rnd8(), rnd8());
    quiesce();

    // random phases, each under its own register setting
    clears_left = 2;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        tx_idle_pct = 53;
        rx_idle_pct <= 13;
      end
      if (ph == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      case (ph)
        0:       {cm, gb, cb} = {1'b1, 3'd4, 3'd5};
        1:       {cm, gb, cb} = {1'b0, 3'd7, 3'd2};
        2:       {cm, gb, cb} = {1'b1, 3'd1, 3'd7};
        3:       {cm, gb, cb} = {1'b0, 3'd1, 3'd6};
        default: {cm, gb, cb} = {1'($urandom), 3'($urandom), 3'($urandom)};
      endcase
      set_config(cm, gb, cb);
      foreach (palette[i]) palette[i] = 24'($urandom);
      // phase 3 keeps the previous color codes in the store
      if (ph != 3) send_item(FUNC_CLEAR, rnd8(), rnd8(), rnd8());
      phase_dones = dones_seen;

      for (int n = 0; n < 150; n++) begin
        if (ph == 0 && n == 100) begin
          // long receiver hold-off while reads keep coming
          hold_go <= 1'b1;
          repeat (16) send_item(FUNC_READ, rnd8(), rnd8(), rnd8());
        end
        roll = $urandom_range(99);
        if (roll < 3) begin
          op = FUNC_UNUSED;
        end else if (roll < 15 && dones_seen == phase_dones) begin
          // reads stop after one exhausted pass; each full scan is costly
          op = FUNC_READ;
        end else if (roll == 99 && clears_left > 0) begin
          op = FUNC_CLEAR;
          clears_left--;
        end else begin
          op = FUNC_ADD;
        end
        pix = $urandom_range(1) ? palette[$urandom_range(7)] : 24'($urandom);
        send_item(op, pix[23:16], pix[15:8], pix[7:0]);
      end
      read_all_bins();
      quiesce();
    end

    if (fail_count == 0 && reports_waiting == 0) begin
      $display("color_histogram_builder regression: pass");
    end else begin
      $display("color_histogram_builder regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("color_histogram_builder regression: fail");
    $finish;
  end

endmodule
